// ----- design/id3_pkg.sv -----
// shared types, constants and helpers for the id3v1 tag field parser
// no dependencies; imported by every module of the block
package id3_pkg;

  // tag layout
  localparam logic [6:0] POS_TITLE   = 7'd3;
  localparam logic [6:0] POS_ARTIST  = 7'd33;
  localparam logic [6:0] POS_ALBUM   = 7'd63;
  localparam logic [6:0] POS_YEAR    = 7'd93;
  localparam logic [6:0] POS_COMMENT = 7'd97;
  localparam logic [6:0] POS_GENRE   = 7'd127;

  localparam logic [4:0] SIZE_MARKER = 5'd3;
  localparam logic [4:0] SIZE_TEXT   = 5'd30;
  localparam logic [4:0] SIZE_YEAR   = 5'd4;
  localparam logic [4:0] SIZE_GENRE  = 5'd1;

  // comment byte that carries the track number in v1.1
  localparam logic [4:0] OFF_TRACK = 5'd29;

  // character constants
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // highest genre code with a known name
  localparam logic [7:0] GENRE_MAX = 8'd147;

  typedef enum logic [2:0] {
    FID_MARKER  = 3'd0,
    FID_TITLE   = 3'd1,
    FID_ARTIST  = 3'd2,
    FID_ALBUM   = 3'd3,
    FID_YEAR    = 3'd4,
    FID_COMMENT = 3'd5,
    FID_GENRE   = 3'd6
  } field_id_t;

  // where the current byte sits in the tag
  typedef struct packed {
    field_id_t  id;
    logic [4:0] off;
    logic [4:0] size;
    logic       text;
    logic       field_end;
    logic       last;
  } loc_t;

  // one result word
  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] field_id;
    logic       field_end;
    logic [4:0] text_length;
    logic       tag_valid;
    logic       is_v11;
    logic [7:0] track_number;
    logic [7:0] genre_code;
    logic       genre_known;
    logic       last;
  } res_t;

  // expected marker character at a marker offset
  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_T;
      2'd1:    c = CHAR_A;
      2'd2:    c = CHAR_G;
      default: c = CHAR_NUL;
    endcase
    return c;
  endfunction

endpackage

// ----- design/id3_locate.sv -----
// position decoder: maps a tag byte position to field, offset and size
// depends on id3_pkg
module id3_locate (
  input  logic [6:0]    pos,
  output id3_pkg::loc_t loc
);
  import id3_pkg::*;

  logic [6:0] base;
  logic [6:0] diff;

  // field lookup by position range
  always_comb begin
    loc = '0;
    base = 7'd0;
    if (pos < POS_TITLE) begin
      loc.id = FID_MARKER;
      loc.size = SIZE_MARKER;
      base = 7'd0;
    end else if (pos < POS_ARTIST) begin
      loc.id = FID_TITLE;
      loc.size = SIZE_TEXT;
      base = POS_TITLE;
    end else if (pos < POS_ALBUM) begin
      loc.id = FID_ARTIST;
      loc.size = SIZE_TEXT;
      base = POS_ARTIST;
    end else if (pos < POS_YEAR) begin
      loc.id = FID_ALBUM;
      loc.size = SIZE_TEXT;
      base = POS_ALBUM;
    end else if (pos < POS_COMMENT) begin
      loc.id = FID_YEAR;
      loc.size = SIZE_YEAR;
      base = POS_YEAR;
    end else if (pos < POS_GENRE) begin
      loc.id = FID_COMMENT;
      loc.size = SIZE_TEXT;
      base = POS_COMMENT;
    end else begin
      loc.id = FID_GENRE;
      loc.size = SIZE_GENRE;
      base = POS_GENRE;
    end
    diff = pos - base;
    loc.off = diff[4:0];
    loc.text = (loc.id != FID_MARKER) && (loc.id != FID_GENRE);
    loc.field_end = (loc.off + 5'd1) == loc.size;
    loc.last = (pos == POS_GENRE);
  end

endmodule

// ----- design/id3_state.sv -----
// per-tag state: position counter, marker check, nul and trim tracking,
// version detection; builds the result word. depends on id3_pkg
module id3_state (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    tag_byte,
  input  logic          tag_start,
  input  id3_pkg::loc_t loc,
  output logic [6:0]    pos,
  output id3_pkg::res_t res
);
  import id3_pkg::*;

  logic [6:0] byte_position_r, byte_position_nxt;
  logic       marker_match_r, marker_match_nxt;
  logic [4:0] first_nul_r, first_nul_nxt;
  logic [4:0] kept_end_r, kept_end_nxt;
  logic       prev_nul_r, prev_nul_nxt;
  logic [7:0] track_r, track_nxt;
  logic       version_r, version_nxt;

  logic       tag_first;
  logic       v11;
  logic [7:0] trim_byte;
  logic [4:0] len;

  // current position, restarted by tag_start
  assign pos = tag_start ? 7'd0 : byte_position_r;
  assign tag_first = (pos == 7'd0);

  // next state
  always_comb begin
    marker_match_nxt = tag_first ? 1'b1 : marker_match_r;
    version_nxt      = tag_first ? 1'b0 : version_r;
    track_nxt        = tag_first ? 8'd0 : track_r;
    first_nul_nxt    = (loc.off == 5'd0) ? loc.size : first_nul_r;
    kept_end_nxt     = (loc.off == 5'd0) ? 5'd0 : kept_end_r;
    v11 = 1'b0;
    trim_byte = tag_byte;

    // marker check
    if (loc.id == FID_MARKER && tag_byte != marker_char(loc.off[1:0])) begin
      marker_match_nxt = 1'b0;
    end

    // text fields: first nul and last kept character
    if (loc.text) begin
      if (loc.id == FID_COMMENT && loc.off == OFF_TRACK) begin
        v11 = !tag_first && prev_nul_r && (tag_byte != CHAR_NUL);
        version_nxt = v11;
        track_nxt = v11 ? tag_byte : 8'd0;
        if (v11) begin
          trim_byte = CHAR_NUL;
        end
      end
      if (trim_byte == CHAR_NUL && loc.off < first_nul_nxt) begin
        first_nul_nxt = loc.off;
      end
      if (trim_byte != CHAR_NUL && trim_byte != CHAR_SPACE) begin
        kept_end_nxt = loc.off + 5'd1;
      end
    end

    prev_nul_nxt = (tag_byte == CHAR_NUL);
    byte_position_nxt = pos + 7'd1;
  end

  // result word
  always_comb begin
    len = (first_nul_nxt < kept_end_nxt) ? first_nul_nxt : kept_end_nxt;
    res.data_byte    = tag_byte;
    res.field_id     = loc.id;
    res.field_end    = loc.field_end;
    res.text_length  = (loc.field_end && loc.text) ? len : 5'd0;
    res.tag_valid    = loc.last && marker_match_nxt;
    res.is_v11       = loc.last && version_nxt;
    res.track_number = (loc.last && version_nxt) ? track_nxt : 8'd0;
    res.genre_code   = loc.last ? tag_byte : 8'd0;
    res.genre_known  = loc.last && (tag_byte <= GENRE_MAX);
    res.last         = loc.last;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= 7'd0;
      marker_match_r  <= 1'b1;
      first_nul_r     <= SIZE_TEXT;
      kept_end_r      <= 5'd0;
      prev_nul_r      <= 1'b0;
      track_r         <= 8'd0;
      version_r       <= 1'b0;
    end else if (accept) begin
      byte_position_r <= byte_position_nxt;
      marker_match_r  <= marker_match_nxt;
      first_nul_r     <= first_nul_nxt;
      kept_end_r      <= kept_end_nxt;
      prev_nul_r      <= prev_nul_nxt;
      track_r         <= track_nxt;
      version_r       <= version_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // nul index never points past a text field
  a_first_nul_range: assert property (@(posedge clk) disable iff (!rst_n)
    first_nul_r <= SIZE_TEXT)
    else $error("first nul index out of range");

  // kept end never points past a text field
  a_kept_end_range: assert property (@(posedge clk) disable iff (!rst_n)
    kept_end_r <= SIZE_TEXT)
    else $error("kept end index out of range");

  // a tag start puts the next byte at position one
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && tag_start |=> byte_position_r == 7'd1)
    else $error("tag start did not restart position");

  // track number is only held together with the version flag
  a_track_needs_v11: assert property (@(posedge clk) disable iff (!rst_n)
    track_r != 8'd0 |-> version_r)
    else $error("track held without v1.1 flag");
`endif

endmodule

// ----- design/id3_out_reg.sv -----
// output register stage: holds one result word and drives the stall back
// to the input side. depends on id3_pkg
module id3_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  id3_pkg::res_t res_in,
  output logic          out_valid,
  input  logic          out_stall,
  output id3_pkg::res_t res_out
);
  import id3_pkg::*;

  logic out_valid_r;
  res_t res_r;

  // free when empty or when the held word leaves this cycle
  assign in_stall = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      res_r <= res_in;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out = res_r;

endmodule

// ----- design/id3v1_tag_field_parser.sv -----
// id3v1 tag field parser, one tag byte in per word, one result word out per byte.
// A new byte is taken every cycle while the output register is free or being
// emptied; each result appears in the cycle after its byte, from a single output
// register, and while that register is full the result stall reaches the input
// stall in the same cycle. All field decoding, marker check, trim length and
// v1.1 detection happen in one pass of logic before that register.
// depends on id3_pkg, id3_locate, id3_state, id3_out_reg
module id3v1_tag_field_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_tag_byte,
  input  logic       in_tag_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic [2:0] out_field_id,
  output logic       out_field_end,
  output logic [4:0] out_text_length,
  output logic       out_tag_valid,
  output logic       out_is_v11,
  output logic [7:0] out_track_number,
  output logic [7:0] out_genre_code,
  output logic       out_genre_known,
  output logic       out_last
);
  import id3_pkg::*;

  logic [6:0] pos;
  loc_t       loc;
  res_t       res;
  res_t       res_q;
  logic       accept;

  assign accept = in_valid && !in_stall;

  // byte position decode
  id3_locate u_locate (
    .pos (pos),
    .loc (loc)
  );

  // per-tag state and result word
  id3_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .tag_byte  (in_tag_byte),
    .tag_start (in_tag_start),
    .loc       (loc),
    .pos       (pos),
    .res       (res)
  );

  // output register
  id3_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .res_in    (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_data_byte    = res_q.data_byte;
  assign out_field_id     = res_q.field_id;
  assign out_field_end    = res_q.field_end;
  assign out_text_length  = res_q.text_length;
  assign out_tag_valid    = res_q.tag_valid;
  assign out_is_v11       = res_q.is_v11;
  assign out_track_number = res_q.track_number;
  assign out_genre_code   = res_q.genre_code;
  assign out_genre_known  = res_q.genre_known;
  assign out_last         = res_q.last;

endmodule

// ----- dv/tb.sv -----
// testbench for id3v1_tag_field_parser: directed and random tag byte streams,
// predicted results checked word by word against the result channel
// depends on id3_pkg and the id3v1_tag_field_parser rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import id3_pkg::*;

  localparam int unsigned TOTAL_BYTES  = 400;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] value;
    logic       start;
  } tag_item_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #10ns clk = ~clk;

  // block ports
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_tag_byte = 8'h00;
  logic       in_tag_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic [2:0] out_field_id;
  logic       out_field_end;
  logic [4:0] out_text_length;
  logic       out_tag_valid;
  logic       out_is_v11;
  logic [7:0] out_track_number;
  logic [7:0] out_genre_code;
  logic       out_genre_known;
  logic       out_last;

  id3v1_tag_field_parser u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tag_byte     (in_tag_byte),
    .in_tag_start    (in_tag_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_field_id    (out_field_id),
    .out_field_end   (out_field_end),
    .out_text_length (out_text_length),
    .out_tag_valid   (out_tag_valid),
    .out_is_v11      (out_is_v11),
    .out_track_number(out_track_number),
    .out_genre_code  (out_genre_code),
    .out_genre_known (out_genre_known),
    .out_last        (out_last)
  );

  // stimulus and result stores
  tag_item_t   tag_bytes_q[$];
  res_t        parsed_words_q[$];
  logic [7:0]  tag_buf[128];
  int unsigned total_items = 1;
  int unsigned sent_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  // parser state mirror
  logic [6:0] tag_pos = 7'd0;
  logic       marker_ok = 1'b1;
  logic [4:0] nul_at = SIZE_TEXT;
  logic [4:0] keep_end = 5'd0;
  logic       last_was_nul = 1'b0;
  logic [7:0] track_val = 8'd0;
  logic       v11_flag = 1'b0;

  // predict the result word for one tag byte and advance the mirror
  function automatic res_t parse_byte(input logic [7:0] value, input logic start);
    logic [6:0] pos;
    logic [6:0] rel;
    field_id_t  fid;
    logic [4:0] off;
    logic [4:0] size;
    logic [7:0] kb;
    logic [7:0] mk;
    logic       is_text;
    logic       at_end;
    logic       at_last;
    logic       v11;
    res_t       r;
    pos = start ? 7'd0 : tag_pos;
    if (pos == 7'd0) begin
      marker_ok = 1'b1;
      v11_flag = 1'b0;
      track_val = 8'd0;
      last_was_nul = 1'b0;
    end
    // field lookup
    if (pos < POS_TITLE) begin
      fid = FID_MARKER; rel = pos; size = SIZE_MARKER;
    end else if (pos < POS_ARTIST) begin
      fid = FID_TITLE; rel = pos - POS_TITLE; size = SIZE_TEXT;
    end else if (pos < POS_ALBUM) begin
      fid = FID_ARTIST; rel = pos - POS_ARTIST; size = SIZE_TEXT;
    end else if (pos < POS_YEAR) begin
      fid = FID_ALBUM; rel = pos - POS_ALBUM; size = SIZE_TEXT;
    end else if (pos < POS_COMMENT) begin
      fid = FID_YEAR; rel = pos - POS_YEAR; size = SIZE_YEAR;
    end else if (pos < POS_GENRE) begin
      fid = FID_COMMENT; rel = pos - POS_COMMENT; size = SIZE_TEXT;
    end else begin
      fid = FID_GENRE; rel = 7'd0; size = SIZE_GENRE;
    end
    off = rel[4:0];
    is_text = (fid != FID_MARKER) && (fid != FID_GENRE);
    if (off == 5'd0) begin
      nul_at = size;
      keep_end = 5'd0;
    end
    // marker compare
    if (fid == FID_MARKER) begin
      case (off)
        5'd0:    mk = CHAR_T;
        5'd1:    mk = CHAR_A;
        default: mk = CHAR_G;
      endcase
      if (value != mk) marker_ok = 1'b0;
    end
    // trim tracking, with the track byte counted as nul in v1.1
    kb = value;
    if (is_text) begin
      if (fid == FID_COMMENT && off == OFF_TRACK) begin
        v11 = last_was_nul && (value != CHAR_NUL);
        v11_flag = v11;
        track_val = v11 ? value : 8'd0;
        if (v11) kb = CHAR_NUL;
      end
      if (kb == CHAR_NUL && off < nul_at) nul_at = off;
      if (kb != CHAR_NUL && kb != CHAR_SPACE) keep_end = off + 5'd1;
    end
    last_was_nul = (value == CHAR_NUL);
    at_end = (off + 5'd1 == size);
    at_last = (pos == POS_GENRE);
    r.data_byte    = value;
    r.field_id     = fid;
    r.field_end    = at_end;
    r.text_length  = (at_end && is_text) ? ((nul_at < keep_end) ? nul_at : keep_end) : 5'd0;
    r.tag_valid    = at_last && marker_ok;
    r.is_v11       = at_last && v11_flag;
    r.track_number = (at_last && v11_flag) ? track_val : 8'd0;
    r.genre_code   = at_last ? value : 8'd0;
    r.genre_known  = at_last && (value <= GENRE_MAX);
    r.last         = at_last;
    tag_pos = pos + 7'd1;
    return r;
  endfunction

  // field compare with report
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // stimulus helpers
  task automatic fill_range(input int lo, input int n, input logic [7:0] v);
    for (int i = 0; i < n; i++) tag_buf[lo + i] = v;
  endtask

  task automatic queue_tag(input logic with_start, input int count);
    tag_item_t it;
    for (int i = 0; i < count; i++) begin
      it.value = tag_buf[i];
      it.start = (i == 0) ? with_start : 1'b0;
      tag_bytes_q.push_back(it);
    end
  endtask

  // one text field with a random padding style
  task automatic rand_text(input int base);
    int unsigned mode;
    int unsigned cut;
    mode = $urandom_range(7);
    cut = $urandom_range(30);
    for (int i = 0; i < 30; i++) begin
      case (mode)
        0: tag_buf[base + i] = CHAR_SPACE;
        1: tag_buf[base + i] = CHAR_NUL;
        2: tag_buf[base + i] = 8'($urandom_range(255));
        3: tag_buf[base + i] = (i < cut) ? 8'($urandom_range(33, 126)) : CHAR_SPACE;
        4: tag_buf[base + i] = (i < cut) ? 8'($urandom_range(33, 126)) : CHAR_NUL;
        5: tag_buf[base + i] = (i < cut) ? 8'($urandom_range(33, 126)) :
                               (i == cut) ? CHAR_NUL : 8'($urandom_range(255));
        6: tag_buf[base + i] = (i < cut) ? 8'($urandom_range(33, 126)) :
                               ($urandom_range(1) ? CHAR_SPACE : CHAR_NUL);
        default: tag_buf[base + i] = (i < cut && $urandom_range(3) != 0) ?
                                     8'($urandom_range(33, 126)) : CHAR_SPACE;
      endcase
    end
  endtask

  // a mostly well formed tag with random content
  task automatic build_random_tag();
    int unsigned pick;
    tag_buf[0] = CHAR_T;
    tag_buf[1] = CHAR_A;
    tag_buf[2] = CHAR_G;
    if ($urandom_range(3) == 0) tag_buf[$urandom_range(2)] = 8'($urandom_range(255));
    rand_text(POS_TITLE);
    rand_text(POS_ARTIST);
    rand_text(POS_ALBUM);
    for (int i = 0; i < 4; i++)
      tag_buf[POS_YEAR + i] = $urandom_range(3) ? 8'($urandom_range(48, 57)) :
                                                 8'($urandom_range(255));
    rand_text(POS_COMMENT);
    pick = $urandom_range(3);
    if (pick == 0) begin
      tag_buf[POS_COMMENT + 28] = CHAR_NUL;
      tag_buf[POS_COMMENT + 29] = 8'($urandom_range(1, 255));
    end else if (pick == 1) begin
      tag_buf[POS_COMMENT + 28] = CHAR_NUL;
      tag_buf[POS_COMMENT + 29] = CHAR_NUL;
    end
    pick = $urandom_range(3);
    tag_buf[POS_GENRE] = (pick == 0) ? 8'($urandom_range(144, 151)) :
                         (pick == 1) ? ($urandom_range(1) ? 8'd0 : 8'd255) :
                                       8'($urandom_range(255));
  endtask

  // idling profile by how far the run has gone
  function automatic int unsigned run_phase();
    return (sent_cnt * 3) / total_items;
  endfunction

  function automatic int unsigned send_idle_pct();
    case (run_phase())
      0:       return 8;
      1:       return 78;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (run_phase())
      0:       return 78;
      1:       return 8;
      default: return 0;
    endcase
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (tag_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
        in_valid     <= 1'b1;
        in_tag_byte  <= tag_bytes_q[0].value;
        in_tag_start <= tag_bytes_q[0].start;
        void'(tag_bytes_q.pop_front());
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  // monitor: predict on accepted bytes, check accepted result words
  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) parsed_words_q.push_back(parse_byte(in_tag_byte, in_tag_start));
      if (out_valid && !out_stall) begin
        got = '{data_byte: out_data_byte, field_id: out_field_id, field_end: out_field_end,
                text_length: out_text_length, tag_valid: out_tag_valid, is_v11: out_is_v11,
                track_number: out_track_number, genre_code: out_genre_code,
                genre_known: out_genre_known, last: out_last};
        if (parsed_words_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual byte %0d",
                   $time, got.data_byte);
          mismatches++;
        end else begin
          want = parsed_words_q.pop_front();
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("field_id", 8'(want.field_id), 8'(got.field_id));
          check_field("field_end", 8'(want.field_end), 8'(got.field_end));
          check_field("text_length", 8'(want.text_length), 8'(got.text_length));
          check_field("tag_valid", 8'(want.tag_valid), 8'(got.tag_valid));
          check_field("is_v11", 8'(want.is_v11), 8'(got.is_v11));
          check_field("track_number", want.track_number, got.track_number);
          check_field("genre_code", want.genre_code, got.genre_code);
          check_field("genre_known", 8'(want.genre_known), 8'(got.genre_known));
          check_field("last", 8'(want.last), 8'(got.last));
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned pick;
    tag_item_t   it;

    // good tag right after reset, no start flag: short title, all-space artist,
    // full 0xff album, v1.1 with track 255, highest known genre
    fill_range(0, 128, CHAR_SPACE);
    tag_buf[0] = CHAR_T;
    tag_buf[1] = CHAR_A;
    tag_buf[2] = CHAR_G;
    tag_buf[POS_TITLE] = 8'h48;
    tag_buf[POS_TITLE + 1] = 8'h69;
    fill_range(POS_ALBUM, 30, 8'hFF);
    fill_range(POS_YEAR, 4, 8'h39);
    tag_buf[POS_COMMENT] = 8'h63;
    tag_buf[POS_COMMENT + 28] = CHAR_NUL;
    tag_buf[POS_COMMENT + 29] = 8'hFF;
    tag_buf[POS_GENRE] = GENRE_MAX;
    queue_tag(1'b0, 128);

    // wrapped tag without start flag: bad marker, nul-led title, nul inside
    // artist, album ending in one letter, comment v1.0, genre just above known
    fill_range(0, 128, CHAR_NUL);
    tag_buf[0] = CHAR_T;
    tag_buf[1] = CHAR_A;
    fill_range(POS_TITLE + 1, 29, 8'h78);
    fill_range(POS_ARTIST, 30, 8'h7A);
    tag_buf[POS_ARTIST + 2] = CHAR_NUL;
    tag_buf[POS_ARTIST + 3] = CHAR_SPACE;
    fill_range(POS_ALBUM, 30, CHAR_SPACE);
    tag_buf[POS_ALBUM + 29] = 8'h71;
    tag_buf[POS_COMMENT + 28] = 8'h01;
    tag_buf[POS_COMMENT + 29] = 8'h01;
    tag_buf[POS_GENRE] = GENRE_MAX + 8'd1;
    queue_tag(1'b0, 128);

    // restart in mid-tag
    build_random_tag();
    queue_tag(1'b1, 40);

    // random tags, some truncated or wrapped, some stray bytes
    while (tag_bytes_q.size() < TOTAL_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 6)) begin
          it.value = 8'($urandom_range(255));
          it.start = 1'($urandom_range(1));
          tag_bytes_q.push_back(it);
        end
      end else begin
        build_random_tag();
        if (pick < 80) queue_tag(1'b1, 128);
        else if (pick < 88) queue_tag(1'b0, 128);
        else queue_tag(1'b1, $urandom_range(1, 127));
      end
    end
    total_items = tag_bytes_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // drain
    while (tag_bytes_q.size() != 0 || in_valid) @(posedge clk);
    while (parsed_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
